/* sv/vthcm_pkg.sv */
// Shared widths, constants and types of the hue colour map.
`default_nettype none
package vthcm_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int SAMPLE_BUS_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int RANGE_W      = 32;
  localparam int CMP_W        = (SAMPLE_WIDTH > RANGE_W) ? SAMPLE_WIDTH + 1 : RANGE_W + 1;
  localparam int OFF_W        = RANGE_W + 1;
  localparam int HUE_W        = 9;
  localparam int CH_W         = 8;
  localparam int NUM_W        = OFF_W + HUE_W;
  localparam int DIVN_W       = NUM_W + 1;
  localparam int DIVD_W       = OFF_W + 1;
  localparam int QUO_W        = HUE_W;
  localparam int RAMP_ARG_W   = 6;
  localparam int OUT_W        = 4 * CH_W;

  localparam int CFG_DATA_W   = RANGE_W;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
  localparam logic [HUE_W-1:0] REGION_SZ = 9'd60;

  // ramp: floor(x / 15300) by reciprocal, one correction step
  localparam int RAMP_SCALE_W = 14;
  localparam int RAMP_X_W     = CH_W + RAMP_SCALE_W;
  localparam int RAMP_RECIP_W = 23;
  localparam int RAMP_PROD_W  = RAMP_X_W + RAMP_RECIP_W;
  localparam int RAMP_SHIFT   = 36;
  localparam logic [RAMP_SCALE_W-1:0] RAMP_SCALE = 14'd15300;
  localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP = 23'd4491469;

  // low level: floor(t / 510) by reciprocal, one correction step
  localparam int P_Y_W       = 2 * CH_W;
  localparam int P_T_W       = P_Y_W + 1;
  localparam int P_DIV_W     = 9;
  localparam int P_RECIP_W   = 18;
  localparam int P_PROD_W    = P_T_W + P_RECIP_W;
  localparam int P_SHIFT     = 26;
  localparam logic [P_DIV_W-1:0]   P_DIV   = 9'd510;
  localparam logic [P_RECIP_W-1:0] P_RECIP = 18'd131586;
  localparam logic [CH_W-1:0]      CH_MAX  = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HUE_START  = 3'd0,
    REG_HUE_END    = 3'd1,
    REG_SATURATION = 3'd2,
    REG_BRIGHTNESS = 3'd3,
    REG_RANGE_LOW  = 3'd4,
    REG_RANGE_HIGH = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue_start;
    logic [HUE_W-1:0]   hue_end;
    logic [CH_W-1:0]    saturation;
    logic [CH_W-1:0]    brightness;
    logic [RANGE_W-1:0] range_low;
    logic [RANGE_W-1:0] range_high;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic below;
    logic above;
    logic neg;
  } ctl_t;

  // alpha in the lowest bits
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
  } pix_t;

endpackage
`default_nettype wire

/* sv/vthcm_front.sv */
// Range classification, offset times hue span, and divider operand set-up.
`default_nettype none
module vthcm_front
  import vthcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire cfg_t                    cfg,
  input  wire logic                    in_valid,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  output logic                         out_valid,
  output ctl_t                         out_ctl,
  output logic [DIVN_W-1:0]            out_n,
  output logic [DIVD_W-1:0]            out_d
);

  logic signed [CMP_W-1:0] s_ext;
  logic signed [CMP_W-1:0] lo_ext;
  logic signed [CMP_W-1:0] hi_ext;
  logic signed [CMP_W-1:0] den_full;
  logic signed [CMP_W-1:0] off_full;
  logic                    neg;
  logic [HUE_W-1:0]        span;
  ctl_t                    ctl0;

  assign s_ext    = CMP_W'($signed(sample));
  assign lo_ext   = CMP_W'($signed(cfg.range_low));
  assign hi_ext   = CMP_W'($signed(cfg.range_high));
  assign den_full = hi_ext - lo_ext;
  assign off_full = s_ext - lo_ext;
  assign neg      = cfg.hue_end < cfg.hue_start;
  assign span     = neg ? cfg.hue_start - cfg.hue_end : cfg.hue_end - cfg.hue_start;

  always_comb begin
    ctl0.empty = den_full <= $signed(CMP_W'(0));
    ctl0.below = s_ext <= lo_ext;
    ctl0.above = s_ext >= hi_ext;
    ctl0.neg   = neg;
  end

  logic             v1;
  ctl_t             c1;
  logic [OFF_W-1:0] off1;
  logic [OFF_W-1:0] den1;
  logic [HUE_W-1:0] span1;
  logic             v2;
  ctl_t             c2;
  logic [NUM_W-1:0] num2;
  logic [OFF_W-1:0] den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1      <= ctl0;
      off1    <= off_full[OFF_W-1:0];
      den1    <= den_full[OFF_W-1:0];
      span1   <= span;
      c2      <= c1;
      num2    <= NUM_W'(off1) * NUM_W'(span1);
      den2    <= den1;
      out_ctl <= c2;
      out_n   <= {num2, 1'b0} + DIVN_W'(den2);
      out_d   <= {den2, 1'b0};
    end
  end

endmodule
`default_nettype wire

/* sv/vthcm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module vthcm_div
  import vthcm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire ctl_t              in_ctl,
  input  wire logic [DIVN_W-1:0] in_n,
  input  wire logic [DIVD_W-1:0] in_d,
  output logic                   out_valid,
  output ctl_t                   out_ctl,
  output logic [QUO_W-1:0]       out_q
);

  logic              vld [1:QUO_W];
  ctl_t              ctl [1:QUO_W];
  logic [QUO_W-1:0]  quo [1:QUO_W];
  logic [DIVN_W-1:0] rem [1:QUO_W-1];
  logic [DIVD_W-1:0] dvs [1:QUO_W-1];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int SH = QUO_W - 1 - i;
    logic              cur_vld;
    ctl_t              cur_ctl;
    logic [QUO_W-1:0]  cur_quo;
    logic [DIVN_W-1:0] cur_rem;
    logic [DIVD_W-1:0] cur_dvs;
    logic [DIVN_W-1:0] trial;
    logic              fits;

    if (i == 0) begin : g_first
      assign cur_vld = in_valid;
      assign cur_ctl = in_ctl;
      assign cur_quo = '0;
      assign cur_rem = in_n;
      assign cur_dvs = in_d;
    end else begin : g_next
      assign cur_vld = vld[i];
      assign cur_ctl = ctl[i];
      assign cur_quo = quo[i];
      assign cur_rem = rem[i];
      assign cur_dvs = dvs[i];
    end

    assign trial = DIVN_W'(cur_dvs) << SH;
    assign fits  = cur_rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[i+1] <= cur_ctl;
        quo[i+1] <= cur_quo | (QUO_W'(fits) << SH);
      end
    end

    if (i < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= fits ? cur_rem - trial : cur_rem;
          dvs[i+1] <= cur_dvs;
        end
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_ctl   = ctl[QUO_W];
  assign out_q     = quo[QUO_W];

endmodule
`default_nettype wire

/* sv/vthcm_hue2rgb.sv */
// Hue selection and HSV to RGB conversion, six register stages.
`default_nettype none
module vthcm_hue2rgb
  import vthcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  input  wire ctl_t             in_ctl,
  input  wire logic [QUO_W-1:0] in_q,
  output logic                  out_valid,
  output pix_t                  out_pix
);

  typedef enum logic [2:0] {
    RGN_RY, RGN_YG, RGN_GC, RGN_CB, RGN_BM, RGN_MR
  } region_t;

  // stage 1: hue
  logic [HUE_W-1:0] hue_raw;
  logic [HUE_W-1:0] hue_wrap;

  always_comb begin
    if (in_ctl.below) begin
      hue_raw = cfg.hue_start;
    end else if (in_ctl.above) begin
      hue_raw = cfg.hue_end;
    end else if (in_ctl.neg) begin
      hue_raw = cfg.hue_start - in_q;
    end else begin
      hue_raw = cfg.hue_start + in_q;
    end
    hue_wrap = (hue_raw >= HUE_FULL) ? hue_raw - HUE_FULL : hue_raw;
  end

  logic             v1, v2, v3, v4, v5;
  logic             e1, e2, e3, e4, e5;
  logic [HUE_W-1:0] h1_hue;

  // stage 2: region and ramp argument
  region_t              rgn;
  logic [HUE_W-1:0]     base;
  logic [HUE_W-1:0]     rem_full;
  logic [RAMP_ARG_W-1:0] rem;
  logic [RAMP_ARG_W-1:0] ramp_arg;

  always_comb begin
    if (h1_hue < REGION_SZ) begin
      rgn = RGN_RY; base = '0;
    end else if (h1_hue < HUE_W'(2 * REGION_SZ)) begin
      rgn = RGN_YG; base = REGION_SZ;
    end else if (h1_hue < HUE_W'(3 * REGION_SZ)) begin
      rgn = RGN_GC; base = HUE_W'(2 * REGION_SZ);
    end else if (h1_hue < HUE_W'(4 * REGION_SZ)) begin
      rgn = RGN_CB; base = HUE_W'(3 * REGION_SZ);
    end else if (h1_hue < HUE_W'(5 * REGION_SZ)) begin
      rgn = RGN_BM; base = HUE_W'(4 * REGION_SZ);
    end else begin
      rgn = RGN_MR; base = HUE_W'(5 * REGION_SZ);
    end
    rem_full = h1_hue - base;
    rem      = rem_full[RAMP_ARG_W-1:0];
    if (rgn == RGN_YG || rgn == RGN_CB || rgn == RGN_MR) begin
      ramp_arg = rem;
    end else begin
      ramp_arg = REGION_SZ[RAMP_ARG_W-1:0] - rem;
    end
  end

  region_t               r2, r3, r4, r5;
  logic [RAMP_ARG_W-1:0] h2_arg;
  logic [P_Y_W-1:0]      h2_y;
  logic [RAMP_SCALE_W-1:0] h3_rs;
  logic [P_T_W-1:0]      h3_t;
  logic [RAMP_X_W-1:0]   h4_x;
  logic [CH_W-1:0]       h4_p0;
  logic [P_T_W-1:0]      h4_t;
  logic [CH_W-1:0]       h5_q0;
  logic [RAMP_X_W-1:0]   h5_x;
  logic [CH_W-1:0]       h5_p;

  logic [P_PROD_W-1:0]    p_prod;
  logic [RAMP_PROD_W-1:0] ramp_prod;
  logic [P_T_W-1:0]       p_res;
  logic [RAMP_X_W-1:0]    ramp_res;
  logic [CH_W-1:0]        ramp;
  logic [CH_W-1:0]        val;
  pix_t                   pix;

  assign p_prod    = P_PROD_W'(h3_t) * P_PROD_W'(P_RECIP);
  assign ramp_prod = RAMP_PROD_W'(h4_x) * RAMP_PROD_W'(RAMP_RECIP);
  assign p_res     = h4_t - P_T_W'(h4_p0) * P_T_W'(P_DIV);
  assign ramp_res  = h5_x - RAMP_X_W'(h5_q0) * RAMP_X_W'(RAMP_SCALE);
  assign ramp      = (ramp_res >= RAMP_X_W'(RAMP_SCALE)) ? h5_q0 + 1'b1 : h5_q0;
  assign val       = cfg.brightness;

  always_comb begin
    pix.alpha = CH_MAX;
    case (r5)
      RGN_YG: begin
        pix.red = ramp; pix.green = val; pix.blue = h5_p;
      end
      RGN_GC: begin
        pix.red = h5_p; pix.green = val; pix.blue = ramp;
      end
      RGN_CB: begin
        pix.red = h5_p; pix.green = ramp; pix.blue = val;
      end
      RGN_BM: begin
        pix.red = ramp; pix.green = h5_p; pix.blue = val;
      end
      RGN_MR: begin
        pix.red = val; pix.green = h5_p; pix.blue = ramp;
      end
      default: begin
        pix.red = val; pix.green = ramp; pix.blue = h5_p;
      end
    endcase
    if (e5) begin
      pix = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1      <= in_ctl.empty;
      h1_hue  <= hue_wrap;
      e2      <= e1;
      r2      <= rgn;
      h2_arg  <= ramp_arg;
      h2_y    <= P_Y_W'(cfg.brightness) * P_Y_W'(CH_MAX - cfg.saturation);
      e3      <= e2;
      r3      <= r2;
      h3_rs   <= RAMP_SCALE_W'(h2_arg) * RAMP_SCALE_W'(cfg.saturation);
      h3_t    <= {h2_y, 1'b0} + P_T_W'(CH_MAX);
      e4      <= e3;
      r4      <= r3;
      h4_x    <= RAMP_X_W'(cfg.brightness) * RAMP_X_W'(RAMP_SCALE - h3_rs);
      h4_p0   <= p_prod[P_SHIFT+CH_W-1:P_SHIFT];
      h4_t    <= h3_t;
      e5      <= e4;
      r5      <= r4;
      h5_q0   <= ramp_prod[RAMP_SHIFT+CH_W-1:RAMP_SHIFT];
      h5_x    <= h4_x;
      h5_p    <= (p_res >= P_T_W'(P_DIV)) ? h4_p0 + 1'b1 : h4_p0;
      out_pix <= pix;
    end
  end

endmodule
`default_nettype wire

/* sv/value_to_hue_color_map.sv */
// Top level of the hue colour map: registers, pipeline and output skid stage.
//
// Takes one fixed-point sample per clock while s_tready is high and returns one
// BGRA colour for each, in order (alpha in the lowest bits). The depth is set
// mainly by the nine-stage restoring divider that forms the hue position inside
// the range, plus three stages of range set-up, six of HSV to RGB conversion
// and the output register. A one-entry skid stage lets the input keep taking
// samples after the output stalls, until a colour has to be held in it; once
// the output frees up the held colour leaves first and the input waits while
// it leaves. Registers are written through the plain write port and must only
// change while no sample is in flight.
`default_nettype none
module value_to_hue_color_map
  import vthcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [SAMPLE_BUS_W-1:0] s_tdata,   // sample
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_W-1:0]             m_tdata    // blue, green, red, alpha (alpha in the lowest bits)
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_start  <= 9'd0;
      cfg.hue_end    <= 9'd359;
      cfg.saturation <= 8'd150;
      cfg.brightness <= 8'd200;
      cfg.range_low  <= 32'd0;
      cfg.range_high <= 32'd655360;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HUE_START:  cfg.hue_start  <= cfg_data[HUE_W-1:0];
        REG_HUE_END:    cfg.hue_end    <= cfg_data[HUE_W-1:0];
        REG_SATURATION: cfg.saturation <= cfg_data[CH_W-1:0];
        REG_BRIGHTNESS: cfg.brightness <= cfg_data[CH_W-1:0];
        REG_RANGE_LOW:  cfg.range_low  <= cfg_data[RANGE_W-1:0];
        REG_RANGE_HIGH: cfg.range_high <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  logic              en;
  logic              skid_valid;
  pix_t              skid_pix;
  logic              f_valid;
  ctl_t              f_ctl;
  logic [DIVN_W-1:0] f_n;
  logic [DIVD_W-1:0] f_d;
  logic              d_valid;
  ctl_t              d_ctl;
  logic [QUO_W-1:0]  d_q;
  logic              p_valid;
  pix_t              p_pix;
  logic              out_free;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign out_free = m_tready || !m_tvalid;

  vthcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .sample    (s_tdata[SAMPLE_WIDTH-1:0]),
    .out_valid (f_valid),
    .out_ctl   (f_ctl),
    .out_n     (f_n),
    .out_d     (f_d)
  );

  vthcm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_ctl    (f_ctl),
    .in_n      (f_n),
    .in_d      (f_d),
    .out_valid (d_valid),
    .out_ctl   (d_ctl),
    .out_q     (d_q)
  );

  vthcm_hue2rgb u_hue2rgb (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ctl    (d_ctl),
    .in_q      (d_q),
    .out_valid (p_valid),
    .out_pix   (p_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= p_valid;
      end
    end else if (p_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_pix : p_pix;
    end else if (!skid_valid) begin
      skid_pix <= p_pix;
    end
  end

  // skid holds data only behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry without output entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled while output was free");

  a_empty_colour: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[CH_W-1:0] == CH_MAX || m_tdata == '0))
    else $error("transparent result with non-zero colour");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for the hue colour map: directed and random samples, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vthcm_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 121;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  class colour_scoreboard;
    cfg_t regs;
    pix_t pending[$];
    int   errors;

    function new();
      regs.hue_start  = 9'd0;
      regs.hue_end    = 9'd359;
      regs.saturation = 8'd150;
      regs.brightness = 8'd200;
      regs.range_low  = 32'd0;
      regs.range_high = 32'd655360;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_HUE_START:  regs.hue_start  = val[HUE_W-1:0];
        REG_HUE_END:    regs.hue_end    = val[HUE_W-1:0];
        REG_SATURATION: regs.saturation = val[CH_W-1:0];
        REG_BRIGHTNESS: regs.brightness = val[CH_W-1:0];
        REG_RANGE_LOW:  regs.range_low  = val;
        REG_RANGE_HIGH: regs.range_high = val;
        default: ;
      endcase
    endfunction

    function int ramp_level(int r);
      int v;
      int sat;
      v   = regs.brightness;
      sat = regs.saturation;
      return (v * (15300 - r * sat)) / 15300;
    endfunction

    function pix_t colour_of(logic [SAMPLE_BUS_W-1:0] smp);
      pix_t   px;
      longint lo, hi, s, den, off, num, quo;
      int     hs, he, span, hue, v, sat, p, rem, up, down;
      bit     neg;
      px = '0;
      lo = $signed(regs.range_low);
      hi = $signed(regs.range_high);
      s  = $signed(smp[SAMPLE_WIDTH-1:0]);
      if (hi <= lo) return px;
      hs = regs.hue_start;
      he = regs.hue_end;
      if (s <= lo) begin
        hue = hs;
      end else if (s >= hi) begin
        hue = he;
      end else begin
        den  = hi - lo;
        off  = s - lo;
        neg  = he < hs;
        span = neg ? hs - he : he - hs;
        num  = off * span;
        quo  = (2 * num + den) / (2 * den);
        hue  = neg ? hs - int'(quo) : hs + int'(quo);
      end
      if (hue >= 360) hue -= 360;
      v    = regs.brightness;
      sat  = regs.saturation;
      p    = (2 * v * (255 - sat) + 255) / 510;
      rem  = hue % 60;
      up   = ramp_level(rem);
      down = ramp_level(60 - rem);
      px.alpha = CH_MAX;
      case (hue / 60)
        1: begin px.red = 8'(up);   px.green = 8'(v);    px.blue = 8'(p);    end
        2: begin px.red = 8'(p);    px.green = 8'(v);    px.blue = 8'(down); end
        3: begin px.red = 8'(p);    px.green = 8'(up);   px.blue = 8'(v);    end
        4: begin px.red = 8'(down); px.green = 8'(p);    px.blue = 8'(v);    end
        5: begin px.red = 8'(v);    px.green = 8'(p);    px.blue = 8'(up);   end
        default: begin px.red = 8'(v); px.green = 8'(down); px.blue = 8'(p); end
      endcase
      return px;
    endfunction

    function void note_sample(logic [SAMPLE_BUS_W-1:0] smp);
      pending.push_back(colour_of(smp));
    endfunction

    function void compare_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_colour(pix_t got);
      pix_t want;
      if (pending.size() == 0) begin
        $display("%0t: colour transfer with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_channel("alpha", want.alpha, got.alpha);
      compare_channel("red",   want.red,   got.red);
      compare_channel("green", want.green, got.green);
      compare_channel("blue",  want.blue,  got.blue);
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [SAMPLE_BUS_W-1:0] s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_W-1:0]        m_tdata;

  colour_scoreboard sb = new();

  int burst_left  = 0;
  bit gaps_on     = 1'b0;
  bit hold_req    = 1'b0;
  int idle_cycles = 0;

  value_to_hue_color_map dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_colour(pix_t'(m_tdata));
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int tick;
    int mode;
    tick = 0;
    mode = 0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (tick % 80 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 2) != 0);
          2: m_tready <= ((tick % 7) < 4);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // upper data bits of the narrow registers carry noise
  task automatic load_settings(input cfg_t c, input bit poke_spare);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    put_reg(REG_HUE_START,  {junk[CFG_DATA_W-1:HUE_W], c.hue_start});
    junk = $urandom;
    put_reg(REG_HUE_END,    {junk[CFG_DATA_W-1:HUE_W], c.hue_end});
    junk = $urandom;
    put_reg(REG_SATURATION, {junk[CFG_DATA_W-1:CH_W], c.saturation});
    junk = $urandom;
    put_reg(REG_BRIGHTNESS, {junk[CFG_DATA_W-1:CH_W], c.brightness});
    put_reg(REG_RANGE_LOW,  c.range_low);
    put_reg(REG_RANGE_HIGH, c.range_high);
    if (poke_spare) begin
      put_reg(REG_SPARE_LO, $urandom);
      put_reg(REG_SPARE_HI, $urandom);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_BUS_W-1:0] smp);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(smp);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [HUE_W-1:0] pick_hue();
    if ($urandom_range(0, 9) == 0) return 9'($urandom_range(360, 511));
    return 9'($urandom_range(0, 359));
  endfunction

  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return CH_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t                 c;
    logic [RANGE_W-1:0]   a, b;
    c.hue_start  = pick_hue();
    c.hue_end    = pick_hue();
    c.saturation = pick_level();
    c.brightness = pick_level();
    a = $urandom;
    b = $urandom;
    if ($signed(a) > $signed(b)) begin
      {a, b} = {b, a};
    end
    case ($urandom_range(0, 9))
      0: begin c.range_low = a; c.range_high = a; end
      1: begin c.range_low = b; c.range_high = a; end
      2: begin c.range_low = 32'h8000_0000; c.range_high = 32'h7fff_ffff; end
      3, 4: begin
        if ($signed(a) > 32'sh7fff_0000) a = '0;
        c.range_low  = a;
        c.range_high = a + 32'($urandom_range(1, 5));
      end
      default: begin c.range_low = a; c.range_high = b; end
    endcase
    return c;
  endfunction

  function automatic logic [SAMPLE_BUS_W-1:0] pick_sample();
    longint            lo, hi;
    longint unsigned   wide;
    lo = $signed(sb.regs.range_low);
    hi = $signed(sb.regs.range_high);
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return lo[SAMPLE_BUS_W-1:0];
      2: return hi[SAMPLE_BUS_W-1:0];
      3: return 32'(lo + 1);
      4: return 32'(hi - 1);
      5: return 32'(lo - 1);
      6: return 32'(hi + 1);
      default: begin
        if (hi <= lo) return $urandom;
        wide = {$urandom, $urandom};
        return 32'(lo + longint'(wide % longint'(hi - lo)));
      end
    endcase
  endfunction

  initial begin
    cfg_t c;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // power-on settings, including the exact half-degree midpoint
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'd1825);
    send_sample(32'd65536);
    send_sample(32'd327680);
    send_sample(32'd655359);
    send_sample(32'd655360);
    send_sample(32'd655361);
    send_sample(32'hffff_ffff);
    settle();

    // widest range, hue end past 359, full saturation and brightness
    c.hue_start  = 9'd0;
    c.hue_end    = 9'd511;
    c.saturation = CH_MAX;
    c.brightness = CH_MAX;
    c.range_low  = 32'h8000_0000;
    c.range_high = 32'h7fff_ffff;
    load_settings(c, 1'b0);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0001);
    send_sample(32'd0);
    send_sample(32'h7fff_fffe);
    send_sample(32'h7fff_ffff);
    settle();

    // falling hue over a two-step range, zero levels, spare indexes poked
    c.hue_start  = 9'd511;
    c.hue_end    = 9'd0;
    c.saturation = 8'd0;
    c.brightness = 8'd0;
    c.range_low  = 32'd0;
    c.range_high = 32'd2;
    load_settings(c, 1'b1);
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'd2);
    settle();

    // empty ranges: equal ends, then reversed ends
    c = random_settings();
    c.range_low  = 32'd5;
    c.range_high = 32'd5;
    load_settings(c, 1'b0);
    send_sample(32'd5);
    settle();
    c.range_low  = 32'd9;
    c.range_high = 32'hffff_fff0;
    load_settings(c, 1'b0);
    send_sample(32'd0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_settings(random_settings(), (ph % 4) == 0);
      gaps_on    = (ph % 3) != 0;
      burst_left = 0;
      if (ph == 5) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
      settle();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
